### rtl/dwsc_pkg.sv
// Shared types, word kind codes, error bit positions and successor tables
// for the readout word stream checker. No dependencies.
`timescale 1ns / 1ps

package dwsc_pkg;

    localparam int WORD_W   = 32;
    localparam int LINK_W   = 20;
    localparam int ERR_W    = 22;

    // Word kinds. Codes follow the successor table layout.
    typedef enum logic [3:0] {
        K_START = 4'd0,
        K_E1    = 4'd1,
        K_E2    = 4'd2,
        K_EH    = 4'd3,
        K_ET    = 4'd4,
        K_PAD   = 4'd5,
        K_PH    = 4'd6,
        K_PT    = 4'd7,
        K_CH    = 4'd8,
        K_CT    = 4'd9,
        K_HIT   = 4'd10,
        K_BAD   = 4'd11
    } t_kind;

    localparam int KIND_N = 12;

    // Type field (bits 30..27) of words with bit 31 set.
    localparam logic [3:0] TYPE_CHIP     = 4'd0;
    localparam logic [3:0] TYPE_PORT_HDR = 4'd1;
    localparam logic [3:0] TYPE_PAD      = 4'd2;
    localparam logic [3:0] TYPE_PORT_TRL = 4'd3;
    localparam logic [3:0] TYPE_E2_LO    = 4'd4;
    localparam logic [3:0] TYPE_E2_HI    = 4'd10;
    localparam logic [4:0] TYPE_E2_BIAS  = 5'd3;

    localparam logic [10:0] E1_MARK      = 11'h7ff;
    localparam logic [2:0]  CHIP_HDR_TAG = 3'd0;
    localparam logic [2:0]  CHIP_TRL_TAG = 3'd7;

    // Error bit positions.
    localparam int ERR_BAD_CHIP     = 0;
    localparam int ERR_EH_LINK      = 8;
    localparam int ERR_ET_NUMBER    = 9;
    localparam int ERR_PH_EVENT     = 10;
    localparam int ERR_PT_PORT      = 11;
    localparam int ERR_PT_EVENT     = 12;
    localparam int ERR_CT_PORT      = 13;
    localparam int ERR_BAD_EVENT    = 14;
    localparam int ERR_TOO_SHORT    = 15;
    localparam int ERR_NOT_EH_FIRST = 16;
    localparam int ERR_DOUBLE_HDR   = 17;
    localparam int ERR_NO_HDR       = 18;
    localparam int ERR_HIT_NO_EVENT = 19;
    localparam int ERR_SUCCESSOR    = 20;
    localparam int ERR_NO_ET_END    = 21;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              first_word;
        logic              last_word;
        logic [LINK_W-1:0] link_event;
    } t_in_item;

    typedef struct packed {
        logic              hit_valid;
        logic [3:0]        hit_geo;
        logic [2:0]        port_number;
        logic [5:0]        hit_channel;
        logic [15:0]       hit_amplitude;
        logic [ERR_W-1:0]  error_bits;
        logic              stopped;
        logic              event_done;
    } t_out_item;

    // Classifier result handed to the tracker.
    typedef struct packed {
        t_kind kind;
        logic  bad_chip;
    } t_class;

    function automatic logic [KIND_N-1:0] f_kind_bit(input t_kind k);
        f_kind_bit = KIND_N'(1) << k;
    endfunction

    function automatic logic [KIND_N-1:0] f_full_next(input t_kind prev);
        case (prev)
            K_START: f_full_next = f_kind_bit(K_EH) | f_kind_bit(K_E1);
            K_EH:    f_full_next = f_kind_bit(K_PAD);
            K_ET:    f_full_next = f_kind_bit(K_EH) | f_kind_bit(K_E1);
            K_PAD:   f_full_next = f_kind_bit(K_PAD) | f_kind_bit(K_PH)
                                 | f_kind_bit(K_ET) | f_kind_bit(K_PT);
            K_PH:    f_full_next = f_kind_bit(K_CH) | f_kind_bit(K_HIT)
                                 | f_kind_bit(K_E2) | f_kind_bit(K_PT)
                                 | f_kind_bit(K_PAD);
            K_PT:    f_full_next = f_kind_bit(K_PH) | f_kind_bit(K_PAD);
            K_CH:    f_full_next = f_kind_bit(K_HIT) | f_kind_bit(K_CT)
                                 | f_kind_bit(K_E2);
            K_CT:    f_full_next = f_kind_bit(K_PT) | f_kind_bit(K_E2)
                                 | f_kind_bit(K_PAD) | f_kind_bit(K_CH);
            K_HIT:   f_full_next = f_kind_bit(K_HIT) | f_kind_bit(K_E2)
                                 | f_kind_bit(K_CT) | f_kind_bit(K_PT)
                                 | f_kind_bit(K_PAD);
            default: f_full_next = '0;
        endcase
    endfunction

    function automatic logic [KIND_N-1:0] f_reduced_next(input t_kind prev);
        case (prev)
            K_START: f_reduced_next = f_kind_bit(K_EH) | f_kind_bit(K_E1);
            K_EH:    f_reduced_next = f_kind_bit(K_E1) | f_kind_bit(K_E2)
                                    | f_kind_bit(K_HIT) | f_kind_bit(K_ET);
            K_ET:    f_reduced_next = f_kind_bit(K_E1) | f_kind_bit(K_EH);
            K_HIT:   f_reduced_next = f_kind_bit(K_E1) | f_kind_bit(K_E2)
                                    | f_kind_bit(K_HIT) | f_kind_bit(K_ET);
            default: f_reduced_next = '0;
        endcase
    endfunction

endpackage

### rtl/dwsc_classifier.sv
// Word classifier: decodes one 32-bit readout word into its kind.
// Depends on dwsc_pkg.
`timescale 1ns / 1ps

module dwsc_classifier (
    input  logic [dwsc_pkg::WORD_W-1:0] i_word,
    output dwsc_pkg::t_class            o_class
);

    always_comb begin
        o_class.bad_chip = 1'b0;
        o_class.kind     = dwsc_pkg::K_BAD;
        if (!i_word[31]) begin
            if (i_word[30:20] == dwsc_pkg::E1_MARK) begin
                o_class.kind = dwsc_pkg::K_E1;
            end else if (i_word[30]) begin
                o_class.kind = dwsc_pkg::K_ET;
            end else begin
                o_class.kind = dwsc_pkg::K_EH;
            end
        end else begin
            case (i_word[30:27])
                dwsc_pkg::TYPE_CHIP: begin
                    if (i_word[23]) begin
                        o_class.kind = dwsc_pkg::K_HIT;
                    end else if (i_word[2:0] == dwsc_pkg::CHIP_HDR_TAG) begin
                        o_class.kind = dwsc_pkg::K_CH;
                    end else if (i_word[2:0] == dwsc_pkg::CHIP_TRL_TAG) begin
                        o_class.kind = dwsc_pkg::K_CT;
                    end else begin
                        o_class.kind     = dwsc_pkg::K_BAD;
                        o_class.bad_chip = 1'b1;
                    end
                end
                dwsc_pkg::TYPE_PORT_HDR: o_class.kind = dwsc_pkg::K_PH;
                dwsc_pkg::TYPE_PAD:      o_class.kind = dwsc_pkg::K_PAD;
                dwsc_pkg::TYPE_PORT_TRL: o_class.kind = dwsc_pkg::K_PT;
                default: begin
                    if (i_word[30:27] >= dwsc_pkg::TYPE_E2_LO &&
                        i_word[30:27] <= dwsc_pkg::TYPE_E2_HI) begin
                        o_class.kind = dwsc_pkg::K_E2;
                    end else begin
                        o_class.kind = dwsc_pkg::K_BAD;
                    end
                end
            endcase
        end
    end

endmodule

### rtl/dwsc_tracker.sv
// Header tracking state and per-word checks; produces one result per word.
// Depends on dwsc_pkg and dwsc_classifier.
`timescale 1ns / 1ps

module dwsc_tracker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  dwsc_pkg::t_in_item  i_item,
    output dwsc_pkg::t_out_item o_result
);

    dwsc_pkg::t_class cls;

    logic [1:0]                  r_words_seen, n_words_seen;
    logic                        r_full, n_full;
    dwsc_pkg::t_kind             r_prev, n_prev;
    logic                        r_event_open, n_event_open;
    logic [19:0]                 r_event_num, n_event_num;
    logic [3:0]                  r_geo, n_geo;
    logic                        r_port_open, n_port_open;
    logic [2:0]                  r_port_num, n_port_num;
    logic [5:0]                  r_port_event, n_port_event;
    logic                        r_chip_open, n_chip_open;
    logic [2:0]                  r_chip_port, n_chip_port;
    logic                        r_stopped, n_stopped;
    logic [dwsc_pkg::LINK_W-1:0] r_expected, n_expected;

    logic                        first;
    logic                        proceed;
    logic                        fatal;
    logic [19:0]                 w_num;
    logic [2:0]                  w_port;
    logic [4:0]                  e2_idx;
    logic [dwsc_pkg::KIND_N-1:0] allowed;
    logic [dwsc_pkg::ERR_W-1:0]  err;

    dwsc_classifier u_classifier (
        .i_word  (i_item.word),
        .o_class (cls)
    );

    assign w_num  = i_item.word[19:0];
    assign w_port = i_item.word[26:24];
    assign e2_idx = {1'b0, i_item.word[30:27]} - dwsc_pkg::TYPE_E2_BIAS;

    always_comb begin
        first        = i_item.first_word || (r_words_seen == 2'd0);
        proceed      = 1'b0;
        fatal        = 1'b0;
        allowed      = '0;
        err          = '0;
        o_result     = '0;

        n_words_seen = r_words_seen;
        n_full       = r_full;
        n_prev       = r_prev;
        n_event_open = r_event_open;
        n_event_num  = r_event_num;
        n_geo        = r_geo;
        n_port_open  = r_port_open;
        n_port_num   = r_port_num;
        n_port_event = r_port_event;
        n_chip_open  = r_chip_open;
        n_chip_port  = r_chip_port;
        n_stopped    = r_stopped;
        n_expected   = r_expected;

        if (first) begin
            n_words_seen = 2'd1;
            n_full       = 1'b0;
            n_prev       = dwsc_pkg::K_START;
            n_event_open = 1'b0;
            n_event_num  = '0;
            n_geo        = '0;
            n_port_open  = 1'b0;
            n_port_num   = '0;
            n_port_event = '0;
            n_chip_open  = 1'b0;
            n_chip_port  = '0;
            n_stopped    = 1'b0;
            n_expected   = i_item.link_event;
            if (i_item.last_word) begin
                err[dwsc_pkg::ERR_TOO_SHORT] = 1'b1;
                n_stopped = 1'b1;
            end else if (cls.kind != dwsc_pkg::K_EH) begin
                err[dwsc_pkg::ERR_BAD_CHIP]     = cls.bad_chip;
                err[dwsc_pkg::ERR_NOT_EH_FIRST] = 1'b1;
                n_stopped = 1'b1;
            end else begin
                proceed = 1'b1;
            end
        end else if (!r_stopped) begin
            if (r_words_seen == 2'd1) begin
                n_full       = (cls.kind == dwsc_pkg::K_PAD);
                n_words_seen = 2'd2;
            end
            proceed = 1'b1;
        end

        // From here the n_ values hold the state as seen by this word.
        if (proceed) begin
            err[dwsc_pkg::ERR_BAD_CHIP] = cls.bad_chip;
            case (cls.kind)
                dwsc_pkg::K_E2: begin
                    err = err | (dwsc_pkg::ERR_W'(1) << e2_idx);
                    o_result.port_number = w_port;
                    if (n_event_open) begin
                        o_result.hit_geo = n_geo;
                    end
                end
                dwsc_pkg::K_EH: begin
                    if (n_event_open) begin
                        err[dwsc_pkg::ERR_DOUBLE_HDR] = 1'b1;
                        fatal = 1'b1;
                    end else begin
                        if (w_num != n_expected) begin
                            err[dwsc_pkg::ERR_EH_LINK] = 1'b1;
                        end
                        n_event_open = 1'b1;
                        n_event_num  = w_num;
                        n_geo        = i_item.word[23:20];
                    end
                end
                dwsc_pkg::K_ET: begin
                    if (!n_event_open) begin
                        err[dwsc_pkg::ERR_NO_HDR] = 1'b1;
                        fatal = 1'b1;
                    end else begin
                        if (w_num != n_event_num) begin
                            err[dwsc_pkg::ERR_ET_NUMBER] = 1'b1;
                        end
                        n_event_open = 1'b0;
                    end
                end
                dwsc_pkg::K_PH: begin
                    if (n_port_open) begin
                        err[dwsc_pkg::ERR_DOUBLE_HDR] = 1'b1;
                        fatal = 1'b1;
                    end else begin
                        if (n_event_open && n_event_num[5:0] != i_item.word[5:0]) begin
                            err[dwsc_pkg::ERR_PH_EVENT] = 1'b1;
                        end
                        n_port_open  = 1'b1;
                        n_port_num   = w_port;
                        n_port_event = i_item.word[5:0];
                    end
                end
                dwsc_pkg::K_PT: begin
                    if (!n_port_open) begin
                        err[dwsc_pkg::ERR_NO_HDR] = 1'b1;
                        fatal = 1'b1;
                    end else begin
                        if (w_port != n_port_num) begin
                            err[dwsc_pkg::ERR_PT_PORT] = 1'b1;
                        end
                        if (i_item.word[5:0] != n_port_event) begin
                            err[dwsc_pkg::ERR_PT_EVENT] = 1'b1;
                        end
                        n_port_open = 1'b0;
                    end
                end
                dwsc_pkg::K_HIT: begin
                    if (!n_event_open) begin
                        err[dwsc_pkg::ERR_HIT_NO_EVENT] = 1'b1;
                        fatal = 1'b1;
                    end else begin
                        o_result.hit_valid     = 1'b1;
                        o_result.hit_geo       = n_geo;
                        o_result.port_number   = w_port;
                        o_result.hit_channel   = i_item.word[21:16];
                        o_result.hit_amplitude = i_item.word[15:0];
                    end
                end
                dwsc_pkg::K_CH: begin
                    if (n_chip_open) begin
                        err[dwsc_pkg::ERR_DOUBLE_HDR] = 1'b1;
                        fatal = 1'b1;
                    end else begin
                        n_chip_open = 1'b1;
                        n_chip_port = w_port;
                    end
                end
                dwsc_pkg::K_CT: begin
                    if (!n_chip_open) begin
                        err[dwsc_pkg::ERR_NO_HDR] = 1'b1;
                        fatal = 1'b1;
                    end else begin
                        if (w_port != n_chip_port) begin
                            err[dwsc_pkg::ERR_CT_PORT] = 1'b1;
                        end
                        n_chip_open = 1'b0;
                    end
                end
                dwsc_pkg::K_BAD: begin
                    fatal = 1'b1;
                end
                default: begin
                end
            endcase

            allowed = n_full ? dwsc_pkg::f_full_next(n_prev)
                             : dwsc_pkg::f_reduced_next(n_prev);

            if (fatal) begin
                err[dwsc_pkg::ERR_BAD_EVENT] = 1'b1;
                n_stopped = 1'b1;
            end else if (cls.kind != dwsc_pkg::K_E1 && cls.kind != dwsc_pkg::K_E2 &&
                         (allowed & dwsc_pkg::f_kind_bit(cls.kind)) == '0) begin
                err[dwsc_pkg::ERR_SUCCESSOR] = 1'b1;
                err[dwsc_pkg::ERR_BAD_EVENT] = 1'b1;
                err[dwsc_pkg::ERR_NO_ET_END] = (cls.kind != dwsc_pkg::K_ET);
                n_stopped = 1'b1;
            end else begin
                if (cls.kind != dwsc_pkg::K_E1 && cls.kind != dwsc_pkg::K_E2) begin
                    n_prev = cls.kind;
                end
                if (i_item.last_word && cls.kind != dwsc_pkg::K_ET) begin
                    err[dwsc_pkg::ERR_NO_ET_END] = 1'b1;
                end
            end
        end

        o_result.error_bits = err;
        o_result.stopped    = n_stopped;
        o_result.event_done = i_item.last_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_words_seen <= 2'd0;
            r_full       <= 1'b0;
            r_prev       <= dwsc_pkg::K_START;
            r_event_open <= 1'b0;
            r_event_num  <= '0;
            r_geo        <= '0;
            r_port_open  <= 1'b0;
            r_port_num   <= '0;
            r_port_event <= '0;
            r_chip_open  <= 1'b0;
            r_chip_port  <= '0;
            r_stopped    <= 1'b0;
            r_expected   <= '0;
        end else if (i_advance) begin
            r_words_seen <= n_words_seen;
            r_full       <= n_full;
            r_prev       <= n_prev;
            r_event_open <= n_event_open;
            r_event_num  <= n_event_num;
            r_geo        <= n_geo;
            r_port_open  <= n_port_open;
            r_port_num   <= n_port_num;
            r_port_event <= n_port_event;
            r_chip_open  <= n_chip_open;
            r_chip_port  <= n_chip_port;
            r_stopped    <= n_stopped;
            r_expected   <= n_expected;
        end
    end

endmodule

### rtl/daq_word_stream_checker_core.sv
// A word is taken into the input register and its result is then written into the result register,
// from which the result transfer is made. Throughput: one word per cycle; the tracking state
// is read combinationally from the input register and written as the word moves into the
// result register, and only a stalled result with a word waiting behind it stalls the input.
// Reset (synchronous, active low) empties both registers and clears all tracking; the next
// word starts a buffer. Depends on dwsc_pkg.
`timescale 1ns / 1ps

module daq_word_stream_checker_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dwsc_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dwsc_pkg::t_out_item o_out_item
);

    logic                r_in_valid;
    dwsc_pkg::t_in_item  r_in;
    logic                r_out_valid;
    dwsc_pkg::t_out_item r_out;
    dwsc_pkg::t_out_item result;
    logic                advance;
    logic                in_take;

    // The held word moves on whenever the result register is free or drains.
    assign advance    = r_in_valid && !(r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    dwsc_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_item;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

### rtl/dwsc_checker.sv
// Port-level checks for the word stream checker, bound to the top level.
// Depends on dwsc_pkg and daq_word_stream_checker_core.
`timescale 1ns / 1ps

module dwsc_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input dwsc_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input dwsc_pkg::t_out_item o_out_item
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result transfer changed");

    a_hit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.hit_valid |->
            !o_out_item.error_bits[dwsc_pkg::ERR_HIT_NO_EVENT] &&
            !o_out_item.error_bits[dwsc_pkg::ERR_NOT_EH_FIRST] &&
            !o_out_item.error_bits[dwsc_pkg::ERR_TOO_SHORT] &&
            !o_out_item.error_bits[dwsc_pkg::ERR_DOUBLE_HDR])
        else $error("hit reported together with a tracking error");

    a_bad_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.error_bits[dwsc_pkg::ERR_BAD_EVENT] |->
            o_out_item.stopped)
        else $error("bad event without stopping the scan");

    a_nonhit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.hit_valid |->
            o_out_item.hit_channel == '0 && o_out_item.hit_amplitude == '0)
        else $error("hit fields set on a word that is not a hit");

endmodule

bind daq_word_stream_checker_core dwsc_checker u_dwsc_checker (.*);
